[src/prm_pkg.sv]
// Shared types, constants and helper functions for the packet route rule matcher.
`timescale 1ns / 1ps

package prm_pkg;

	localparam int MASK_W = 11;
	localparam int RULE_W = 32;
	localparam int ADDR_W = 10;
	localparam int HOP_W  = 4;
	localparam int PORT_W = 4;
	localparam int CNT_W  = 3;
	localparam int IDX_W  = 3;

	// Rule field encodings
	localparam logic [1:0]        TYPE_MULTIPLE = 2'd1;
	localparam logic [1:0]        TYPE_ANY      = 2'd2;
	localparam logic [PORT_W-1:0] PORT_ANY      = 4'd12;
	localparam logic [3:0]        OUT_DROP      = 4'd0;
	localparam logic [3:0]        OUT_LAST_IF   = 4'd10;
	localparam logic [3:0]        OUT_ALL       = 4'd11;

	// Register reset values
	localparam logic [CNT_W-1:0]  RULE_COUNT_RST = 3'd2;
	localparam logic [RULE_W-1:0] RULE_ZERO_RST  = 32'h8C00_0800;
	localparam logic [RULE_W-1:0] RULE_ONE_RST   = 32'h0C80_0800;

	typedef enum logic [IDX_W-1:0] {
		REG_RULE_COUNT = 3'd0,
		REG_RULE_ZERO  = 3'd1,
		REG_RULE_ONE   = 3'd2,
		REG_RULE_TWO   = 3'd3,
		REG_RULE_THREE = 3'd4
	} cfg_idx_t;

	// Per-packet status carried with the rule hits through the queue
	typedef struct packed {
		logic [HOP_W-1:0] hop_left;
		logic             expired;
	} hdr_res_t;

	// Queue mask for one output code; interface bits at or above num_queues fall to drop
	function automatic logic [MASK_W-1:0] queue_bits(input logic [3:0] code, input int num_queues);
		logic [MASK_W-1:0] mask;
		mask = '0;
		if (code != OUT_DROP && code <= OUT_LAST_IF) begin
			if (int'(code) < num_queues) begin
				mask = MASK_W'(1) << code;
			end else begin
				mask = MASK_W'(1);
			end
		end else if (code == OUT_ALL) begin
			for (int q = 1; q <= int'(OUT_LAST_IF); q++) begin
				if (q < num_queues) begin
					mask[q] = 1'b1;
				end
			end
		end else begin
			mask = MASK_W'(1);
		end
		return mask;
	endfunction

endpackage

[src/packet_route_rule_matcher_top.sv]
// A header is written into the queue, and the sequencer registers its results at the output, one per hit.
// Throughput: one header per cycle while each gives one result and out_stall is low; the result
// sequencer emits one result per cycle unless out_stall is high, and the two-entry queue
// stalls the input when multi-hit packets back up. Reset (async, active low): rule_count 2,
// rule_zero 0x8C000800, rule_one 0x0C800800, other rules 0, queue empty, no result pending.
`timescale 1ns / 1ps

module packet_route_rule_matcher_top #(
	parameter int NUM_RULES  = 4,
	parameter int NUM_QUEUES = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [prm_pkg::ADDR_W-1:0]  src_address,
	input  logic [prm_pkg::ADDR_W-1:0]  dst_address,
	input  logic [prm_pkg::HOP_W-1:0]   hop_limit,
	input  logic [prm_pkg::PORT_W-1:0]  arrival_port,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [prm_pkg::MASK_W-1:0]  queue_mask,
	output logic [prm_pkg::HOP_W-1:0]   hop_left,
	output logic                        expired,
	output logic                        no_match,
	output logic                        last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [prm_pkg::IDX_W-1:0]   cfg_index,
	input  logic [prm_pkg::RULE_W-1:0]  cfg_data
);

	localparam int QDEPTH = 2;
	localparam int QW     = NUM_RULES + NUM_RULES * prm_pkg::MASK_W + $bits(prm_pkg::hdr_res_t);

	logic [prm_pkg::CNT_W-1:0]                   rule_count_q;
	logic [NUM_RULES-1:0][prm_pkg::RULE_W-1:0]   rules_q;

	logic [NUM_RULES-1:0]                        f_emit;
	logic [NUM_RULES-1:0][prm_pkg::MASK_W-1:0]   f_masks;
	prm_pkg::hdr_res_t                           f_info;

	logic [NUM_RULES-1:0]                        b_emit;
	logic [NUM_RULES-1:0][prm_pkg::MASK_W-1:0]   b_masks;
	prm_pkg::hdr_res_t                           b_info;

	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_head_valid;
	logic [QW-1:0] q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= prm_pkg::RULE_COUNT_RST;
			// with a single slot, rule_one's reset value lands in slot zero
			for (int i = 0; i < NUM_RULES; i++) begin
				if (i == 1 % NUM_RULES) begin
					rules_q[i] <= prm_pkg::RULE_ONE_RST;
				end else if (i == 0) begin
					rules_q[i] <= prm_pkg::RULE_ZERO_RST;
				end else begin
					rules_q[i] <= '0;
				end
			end
		end else if (cfg_valid && cfg_ready) begin
			case (prm_pkg::cfg_idx_t'(cfg_index))
				prm_pkg::REG_RULE_COUNT: begin
					rule_count_q <= cfg_data[prm_pkg::CNT_W-1:0];
				end
				prm_pkg::REG_RULE_ZERO, prm_pkg::REG_RULE_ONE,
				prm_pkg::REG_RULE_TWO, prm_pkg::REG_RULE_THREE: begin
					// rule slots past NUM_RULES drop the write
					for (int i = 0; i < NUM_RULES; i++) begin
						if (int'(cfg_index) - int'(prm_pkg::REG_RULE_ZERO) == i) begin
							rules_q[i] <= cfg_data;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	prm_front #(
		.NUM_RULES  (NUM_RULES),
		.NUM_QUEUES (NUM_QUEUES)
	) u_front (
		.src_address  (src_address),
		.dst_address  (dst_address),
		.hop_limit    (hop_limit),
		.arrival_port (arrival_port),
		.rule_count   (rule_count_q),
		.rules        (rules_q),
		.emit         (f_emit),
		.masks        (f_masks),
		.info         (f_info)
	);

	assign in_stall = q_full;
	assign q_push   = in_valid && !in_stall;

	prm_queue #(
		.W     (QW),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  ({f_info, f_masks, f_emit}),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_data  (q_head)
	);

	assign {b_info, b_masks, b_emit} = q_head;

	prm_back #(
		.NUM_RULES (NUM_RULES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.emit       (b_emit),
		.masks      (b_masks),
		.info       (b_info),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.queue_mask (queue_mask),
		.hop_left   (hop_left),
		.expired    (expired),
		.no_match   (no_match),
		.last       (last)
	);

	// Expired results are single, unrouted and carry no hop count
	a_expired_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired |-> last && !no_match && queue_mask == '0 && hop_left == '0)
		else $error("expired result malformed");

	// A miss is a single result with an empty mask
	a_no_match_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_match |-> last && queue_mask == '0)
		else $error("no_match result malformed");

	// Every rule hit selects at least one queue
	a_hit_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !expired && !no_match |-> queue_mask != '0)
		else $error("rule hit with empty queue mask");

	// A result that is taken and not last is followed by more results of the same packet
	a_multi_hit_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && !expired && !no_match)
		else $error("packet ended without a last result");

endmodule

[src/prm_queue.sv]
// Small register-based FIFO between the classifier front end and the result sequencer.
`timescale 1ns / 1ps

module prm_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         head_valid,
	output logic [W-1:0] head_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		if (p == PW'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PW'(1);
		end
		return n;
	endfunction

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[src/prm_front.sv]
// Classifier front end: compares a header against all rules at once and picks the emitting ones.
`timescale 1ns / 1ps

module prm_front #(
	parameter int NUM_RULES  = 4,
	parameter int NUM_QUEUES = 11
) (
	input  logic [prm_pkg::ADDR_W-1:0]                  src_address,
	input  logic [prm_pkg::ADDR_W-1:0]                  dst_address,
	input  logic [prm_pkg::HOP_W-1:0]                   hop_limit,
	input  logic [prm_pkg::PORT_W-1:0]                  arrival_port,
	input  logic [prm_pkg::CNT_W-1:0]                   rule_count,
	input  logic [NUM_RULES-1:0][prm_pkg::RULE_W-1:0]   rules,
	output logic [NUM_RULES-1:0]                        emit,
	output logic [NUM_RULES-1:0][prm_pkg::MASK_W-1:0]   masks,
	output prm_pkg::hdr_res_t                           info
);

	logic [NUM_RULES-1:0] hit;
	logic [NUM_RULES-1:0] stop;
	logic                 is_expired;

	assign is_expired = (hop_limit == '0);

	always_comb begin
		for (int i = 0; i < NUM_RULES; i++) begin
			logic [prm_pkg::ADDR_W-1:0] r_src;
			logic [1:0]                 r_stype;
			logic [prm_pkg::ADDR_W-1:0] r_dst;
			logic [1:0]                 r_dtype;
			logic [prm_pkg::PORT_W-1:0] r_in;
			logic [3:0]                 r_out;
			r_src   = rules[i][9:0];
			r_stype = rules[i][11:10];
			r_dst   = rules[i][21:12];
			r_dtype = rules[i][23:22];
			r_in    = rules[i][27:24];
			r_out   = rules[i][31:28];
			hit[i]  = (int'(rule_count) > i)
				&& (r_stype == prm_pkg::TYPE_ANY || r_src == src_address)
				&& (r_dtype == prm_pkg::TYPE_ANY || r_dst == dst_address)
				&& (r_in == prm_pkg::PORT_ANY || r_in == arrival_port);
			stop[i]  = hit[i] && (r_dtype != prm_pkg::TYPE_MULTIPLE);
			masks[i] = prm_pkg::queue_bits(r_out, NUM_QUEUES);
		end
	end

	// A hit counts only if the header has not expired and no earlier rule ended the search
	always_comb begin
		logic blocked;
		blocked = is_expired;
		for (int i = 0; i < NUM_RULES; i++) begin
			emit[i] = hit[i] && !blocked;
			blocked = blocked || stop[i];
		end
	end

	always_comb begin
		info.expired  = is_expired;
		info.hop_left = is_expired ? '0 : hop_limit - prm_pkg::HOP_W'(1);
	end

endmodule

[src/prm_back.sv]
// Result sequencer: walks head packet hits, one result per cycle if out_stall is low.
`timescale 1ns / 1ps

module prm_back #(
	parameter int NUM_RULES = 4
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      head_valid,
	input  logic [NUM_RULES-1:0]                      emit,
	input  logic [NUM_RULES-1:0][prm_pkg::MASK_W-1:0] masks,
	input  prm_pkg::hdr_res_t                         info,
	output logic                                      pop,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic [prm_pkg::MASK_W-1:0]                queue_mask,
	output logic [prm_pkg::HOP_W-1:0]                 hop_left,
	output logic                                      expired,
	output logic                                      no_match,
	output logic                                      last
);

	logic [NUM_RULES-1:0]       done_q;
	logic [NUM_RULES-1:0]       pending;
	logic [NUM_RULES-1:0]       sel;
	logic                       load;
	logic                       special;
	logic                       last_c;
	logic [prm_pkg::MASK_W-1:0] mask_c;

	logic                       out_valid_q;
	logic [prm_pkg::MASK_W-1:0] queue_mask_q;
	logic [prm_pkg::HOP_W-1:0]  hop_left_q;
	logic                       expired_q;
	logic                       no_match_q;
	logic                       last_q;

	assign pending = emit & ~done_q;
	assign sel     = pending & (~pending + NUM_RULES'(1));
	assign special = (emit == '0);
	assign load    = head_valid && (!out_valid_q || !out_stall);
	assign last_c  = special || ((pending & ~sel) == '0);
	assign pop     = load && last_c;

	always_comb begin
		mask_c = '0;
		for (int i = 0; i < NUM_RULES; i++) begin
			if (sel[i]) begin
				mask_c = mask_c | masks[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				done_q <= '0;
			end else if (load) begin
				done_q <= done_q | sel;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			queue_mask_q <= special ? '0 : mask_c;
			hop_left_q   <= info.hop_left;
			expired_q    <= info.expired;
			no_match_q   <= special && !info.expired;
			last_q       <= last_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign queue_mask = queue_mask_q;
	assign hop_left   = hop_left_q;
	assign expired    = expired_q;
	assign no_match   = no_match_q;
	assign last       = last_q;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the packet route rule matcher: directed and random headers.
`timescale 1ns / 1ps

module tb_top;
	import prm_pkg::*;

	localparam int NUM_RULES  = 4;
	localparam int NUM_QUEUES = 11;

	localparam logic [1:0]        TYPE_SINGLE     = 2'd0;
	localparam logic [1:0]        TYPE_SINGLE_ALT = 2'd3;
	localparam logic [3:0]        OUT_FIRST_IF    = 4'd1;
	localparam logic [3:0]        OUT_MID_IF      = 4'd5;
	localparam logic [3:0]        OUT_INVALID_LO  = 4'd12;
	localparam logic [3:0]        OUT_INVALID_HI  = 4'd15;
	localparam logic [PORT_W-1:0] PORT_UNKNOWN    = 4'd0;
	localparam logic [PORT_W-1:0] PORT_LAST_IF    = 4'd10;
	localparam logic [PORT_W-1:0] PORT_TOP        = 4'd15;
	localparam logic [MASK_W-1:0] DROP_QUEUE      = 11'd1;
	localparam int                RANDOM_PHASES   = 7;
	localparam int                HEADERS_PER_PHASE = 50;

	typedef struct packed {
		logic [3:0]        out_code;
		logic [PORT_W-1:0] port;
		logic [1:0]        dst_type;
		logic [ADDR_W-1:0] dst;
		logic [1:0]        src_type;
		logic [ADDR_W-1:0] src;
	} rule_t;

	typedef struct packed {
		logic [MASK_W-1:0] queue_mask;
		logic [HOP_W-1:0]  hop_left;
		logic              expired;
		logic              no_match;
		logic              last;
	} route_t;

	class route_scoreboard;
		logic [CNT_W-1:0] rule_count;
		rule_t            rules[NUM_RULES];
		route_t           expected_routes[$];
		int               errors;

		function new();
			rule_count = RULE_COUNT_RST;
			rules[0] = RULE_ZERO_RST;
			rules[1] = RULE_ONE_RST;
			rules[2] = '0;
			rules[3] = '0;
			errors = 0;
		endfunction

		function void write_register(logic [IDX_W-1:0] idx, logic [RULE_W-1:0] data);
			case (idx)
				REG_RULE_COUNT: rule_count = data[CNT_W-1:0];
				REG_RULE_ZERO:  rules[0] = data;
				REG_RULE_ONE:   rules[1] = data;
				REG_RULE_TWO:   rules[2] = data;
				REG_RULE_THREE: rules[3] = data;
				default: ;
			endcase
		endfunction

		function logic [MASK_W-1:0] mask_for(logic [3:0] code);
			logic [MASK_W-1:0] m;
			m = DROP_QUEUE;
			if (code != OUT_DROP && code <= OUT_LAST_IF) begin
				if (int'(code) < NUM_QUEUES) m = MASK_W'(1) << code;
			end else if (code == OUT_ALL) begin
				m = '0;
				for (int q = 1; q <= int'(OUT_LAST_IF) && q < NUM_QUEUES; q++) m[q] = 1'b1;
			end
			return m;
		endfunction

		// Note an accepted header and queue the routes it must produce.
		function void predict_routes(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
				logic [HOP_W-1:0] hop, logic [PORT_W-1:0] port);
			route_t r;
			route_t hits[$];
			rule_t  rl;
			int     used;
			bit     hit;
			if (hop == '0) begin
				r = '{queue_mask: '0, hop_left: '0, expired: 1'b1, no_match: 1'b0, last: 1'b1};
				expected_routes.push_back(r);
				return;
			end
			used = (int'(rule_count) > NUM_RULES) ? NUM_RULES : int'(rule_count);
			for (int i = 0; i < used; i++) begin
				rl = rules[i];
				hit = (rl.src_type == TYPE_ANY || rl.src == src) &&
					(rl.dst_type == TYPE_ANY || rl.dst == dst) &&
					(rl.port == PORT_ANY || rl.port == port);
				if (hit) begin
					r = '{queue_mask: mask_for(rl.out_code), hop_left: hop - 1'b1,
						expired: 1'b0, no_match: 1'b0, last: 1'b0};
					hits.push_back(r);
					if (rl.dst_type != TYPE_MULTIPLE) break;
				end
			end
			if (hits.size() == 0) begin
				r = '{queue_mask: '0, hop_left: hop - 1'b1, expired: 1'b0, no_match: 1'b1,
					last: 1'b1};
				hits.push_back(r);
			end else begin
				r = hits[hits.size() - 1];
				r.last = 1'b1;
				hits[hits.size() - 1] = r;
			end
			foreach (hits[k]) expected_routes.push_back(hits[k]);
		endfunction

		function void report_field(string name, int want, int got);
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			errors++;
		endfunction

		function void check_route(route_t got);
			route_t want;
			if (expected_routes.size() == 0) begin
				$display("%0t: unexpected route mask %0h hop %0h expired %0b no_match %0b last %0b",
					$time, got.queue_mask, got.hop_left, got.expired, got.no_match, got.last);
				errors++;
				return;
			end
			want = expected_routes.pop_front();
			if (got.queue_mask !== want.queue_mask)
				report_field("queue_mask", want.queue_mask, got.queue_mask);
			if (got.hop_left !== want.hop_left)
				report_field("hop_left", want.hop_left, got.hop_left);
			if (got.expired !== want.expired) report_field("expired", want.expired, got.expired);
			if (got.no_match !== want.no_match)
				report_field("no_match", want.no_match, got.no_match);
			if (got.last !== want.last) report_field("last", want.last, got.last);
		endfunction

		function int pending_count();
			return expected_routes.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [ADDR_W-1:0] src_address = '0;
	logic [ADDR_W-1:0] dst_address = '0;
	logic [HOP_W-1:0]  hop_limit = '0;
	logic [PORT_W-1:0] arrival_port = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [MASK_W-1:0] queue_mask;
	logic [HOP_W-1:0]  hop_left;
	logic              expired;
	logic              no_match;
	logic              last;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [RULE_W-1:0] cfg_data = '0;

	int                in_idle_pct = 22;
	int                out_idle_pct = 45;
	logic [ADDR_W-1:0] addr_pool[4];
	logic [PORT_W-1:0] port_pool[3];
	route_scoreboard   sb = new();

	packet_route_rule_matcher_top #(
		.NUM_RULES(NUM_RULES),
		.NUM_QUEUES(NUM_QUEUES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.src_address(src_address),
		.dst_address(dst_address),
		.hop_limit(hop_limit),
		.arrival_port(arrival_port),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.queue_mask(queue_mask),
		.hop_left(hop_left),
		.expired(expired),
		.no_match(no_match),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= (out_idle_pct > 0) && ($urandom_range(99) < out_idle_pct);
	end

	// Sample every transfer with pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall === 1'b0)
				sb.predict_routes(src_address, dst_address, hop_limit, arrival_port);
			if (out_valid === 1'b1 && !out_stall)
				sb.check_route('{queue_mask, hop_left, expired, no_match, last});
			if (cfg_valid && cfg_ready === 1'b1) sb.write_register(cfg_index, cfg_data);
		end
	end

	function automatic rule_t make_rule(logic [3:0] out_code, logic [PORT_W-1:0] port,
			logic [1:0] dst_type, logic [ADDR_W-1:0] dst, logic [1:0] src_type,
			logic [ADDR_W-1:0] src);
		rule_t r;
		r.out_code = out_code;
		r.port = port;
		r.dst_type = dst_type;
		r.dst = dst;
		r.src_type = src_type;
		r.src = src;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		return ($urandom_range(99) < 80) ? addr_pool[$urandom_range(3)] : ADDR_W'($urandom);
	endfunction

	function automatic logic [PORT_W-1:0] pick_port();
		return ($urandom_range(99) < 80) ? port_pool[$urandom_range(2)] : PORT_W'($urandom);
	endfunction

	function automatic rule_t random_rule();
		logic [1:0] dtype;
		logic [PORT_W-1:0] port;
		dtype = ($urandom_range(99) < 40) ? TYPE_MULTIPLE : 2'($urandom);
		port = ($urandom_range(3) == 0) ? PORT_ANY : pick_port();
		return make_rule(4'($urandom), port, dtype, pick_addr(), 2'($urandom), pick_addr());
	endfunction

	task automatic refresh_pools();
		foreach (addr_pool[k]) begin
			case ($urandom_range(5))
				0: addr_pool[k] = '0;
				1: addr_pool[k] = '1;
				default: addr_pool[k] = ADDR_W'($urandom);
			endcase
		end
		foreach (port_pool[k]) port_pool[k] = PORT_W'($urandom);
	endtask

	// Hold cfg_valid high across back-to-back writes; the caller lowers it.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RULE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
	endtask

	task automatic apply_rules(input logic [CNT_W-1:0] count, input rule_t r0, input rule_t r1,
			input rule_t r2, input rule_t r3, input int stray_writes);
		write_reg(REG_RULE_ZERO, r0);
		write_reg(REG_RULE_ONE, r1);
		write_reg(REG_RULE_TWO, r2);
		write_reg(REG_RULE_THREE, r3);
		for (int k = 0; k < stray_writes; k++)
			write_reg(IDX_W'($urandom_range((1 << IDX_W) - 1, int'(REG_RULE_THREE) + 1)),
				RULE_W'($urandom));
		write_reg(REG_RULE_COUNT, {(RULE_W - CNT_W)'($urandom), count});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_header(input logic [ADDR_W-1:0] s, input logic [ADDR_W-1:0] d,
			input logic [HOP_W-1:0] h, input logic [PORT_W-1:0] p);
		// idle each cycle with the given odds
		while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		src_address <= s;
		dst_address <= d;
		hop_limit <= h;
		arrival_port <= p;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// Drop valid and hold until every queued route has come out.
	task automatic wait_routes_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_count() != 0);
	endtask

	initial begin
		#5_000_000;
		$display("packet_route_rule_matcher_top: mismatch");
		$finish;
	end

	initial begin
		int counts[RANDOM_PHASES];
		counts = '{4, 7, 3, 1, 4, 0, 6};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset rules: exact destination zero to queue 8, then catch-all drop
		send_header('0, '0, 4'hF, PORT_UNKNOWN);
		send_header('1, '1, 4'd1, PORT_TOP);
		send_header(10'h155, '0, '0, PORT_LAST_IF);
		wait_routes_drained();

		// chain of multiple-type rules: drop, broadcast, invalid and single queue
		apply_rules(3'd4,
			make_rule(OUT_DROP, PORT_ANY, TYPE_MULTIPLE, 10'h155, TYPE_ANY, '0),
			make_rule(OUT_ALL, PORT_ANY, TYPE_MULTIPLE, 10'h155, TYPE_ANY, '0),
			make_rule(OUT_INVALID_LO, PORT_ANY, TYPE_MULTIPLE, 10'h155, TYPE_ANY, '0),
			make_rule(OUT_FIRST_IF, PORT_ANY, TYPE_MULTIPLE, 10'h155, TYPE_ANY, '0), 0);
		send_header(10'h2AA, 10'h155, 4'd3, 4'd7);
		send_header(10'h155, 10'h2AA, 4'd3, 4'd7);
		send_header(10'h155, 10'h155, '0, 4'd7);
		wait_routes_drained();

		// count above the rule table saturates; all-ones rule; catch-all broadcast
		apply_rules(3'd7,
			make_rule(OUT_LAST_IF, PORT_LAST_IF, TYPE_ANY, '0, TYPE_SINGLE_ALT, 10'h2AA),
			make_rule(OUT_INVALID_HI, PORT_TOP, TYPE_SINGLE_ALT, '1, TYPE_SINGLE_ALT, '1),
			make_rule(OUT_MID_IF, PORT_UNKNOWN, TYPE_MULTIPLE, '0, TYPE_SINGLE, '0),
			make_rule(OUT_ALL, PORT_ANY, TYPE_ANY, '0, TYPE_ANY, '0), 0);
		send_header(10'h2AA, 10'h3C3, 4'hF, PORT_LAST_IF);
		send_header('1, '1, 4'd8, PORT_TOP);
		send_header('0, '0, 4'd2, PORT_UNKNOWN);
		send_header(10'h123, 10'h045, 4'd1, PORT_ANY);
		wait_routes_drained();

		// no rules in use; writes past the register list must be ignored
		apply_rules(3'd0, '1, '1, '1, '1, 3);
		send_header('0, '0, 4'd1, PORT_UNKNOWN);
		send_header('1, '1, 4'hF, PORT_TOP);
		send_header('1, '0, '0, PORT_ANY);
		wait_routes_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 2) begin
				in_idle_pct = 22;
				out_idle_pct = 45;
			end else if (ph < 4) begin
				in_idle_pct = 45;
				out_idle_pct = 22;
			end else begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			refresh_pools();
			apply_rules(CNT_W'(counts[ph]), random_rule(), random_rule(), random_rule(),
				random_rule(), ($urandom_range(2) == 0) ? 1 : 0);
			for (int n = 0; n < HEADERS_PER_PHASE; n++) begin
				send_header(pick_addr(), pick_addr(), HOP_W'($urandom), pick_port());
				if ($urandom_range(99) < 2) wait_routes_drained();
			end
			wait_routes_drained();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_count() == 0) begin
			$display("packet_route_rule_matcher_top: match");
		end else begin
			$display("packet_route_rule_matcher_top: mismatch");
		end
		$finish;
	end

endmodule
